/* sv/ttu_pkg.sv */
// Shared types and constants for the triangle tangent unit.
package ttu_pkg;

    // Field widths of the vertex and tangent words
    localparam int POS_W = 24;
    localparam int TEX_W = 20;
    localparam int TAN_W = 16;

    // Largest tangent component magnitude
    localparam logic [TAN_W-1:0] TAN_MAX = TAN_W'((1 << (TAN_W - 1)) - 1);

    // Sequencer step counts
    localparam int MUL_STEPS  = 8;
    localparam int SQ_STEPS   = 3;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = TAN_W + 1;
    localparam int CNT_W      = 6;

    // Input word: one vertex
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [TEX_W-1:0] tex_u;
        logic signed [TEX_W-1:0] tex_v;
    } t_vtx;

    // Output word: one triangle tangent
    typedef struct packed {
        logic signed [TAN_W-1:0] tangent_x;
        logic signed [TAN_W-1:0] tangent_y;
        logic signed [TAN_W-1:0] tangent_z;
        logic                    degenerate;
    } t_res;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic       load_vtx;
        logic       vtx_slot;
        logic       load_last;
        logic       diff;
        logic       mul_en;
        logic [2:0] mul_idx;
        logic       mag;
        logic       norm;
        logic       sq_clr;
        logic       sq_en;
        logic [1:0] sq_idx;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic [1:0] comp;
        logic       out_load;
    } t_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic degen;
        logic norm_done;
        logic out_free;
    } t_sts;

endpackage

/* sv/ttu_dp.sv */
// Datapath: vertex store, shared multiplier, normalizer, square root and divider.
module ttu_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ttu_pkg::t_vtx i_vtx,
    input  ttu_pkg::t_cmd i_cmd,
    output ttu_pkg::t_sts o_sts,
    output logic          o_res_valid,
    output ttu_pkg::t_res o_res,
    input  logic          i_res_stall
);
    import ttu_pkg::*;

    localparam int POS_DROP = (POS_W + 1 > 32) ? (POS_W + 1 - 32) : 0;
    localparam int EW       = POS_W + 1 - POS_DROP;
    localparam int UV_DROP  = (TEX_W + 1 > 28) ? (TEX_W + 1 - 28) : 0;
    localparam int UW       = TEX_W + 1 - UV_DROP;
    localparam int MB       = (EW > UW) ? EW : UW;
    localparam int PRW      = UW + MB;
    localparam int AW       = PRW + 1;
    localparam int NW       = (AW > 32) ? AW : 32;
    localparam int QB       = TAN_W + 1;
    localparam int DW       = 31 + TAN_W;

    logic signed [POS_W-1:0] r_p0 [3];
    logic signed [POS_W-1:0] r_p1 [3];
    logic signed [POS_W-1:0] r_p2 [3];
    logic signed [TEX_W-1:0] r_u0, r_v0, r_u1, r_v1, r_u2, r_v2;
    logic signed [EW-1:0]    r_e1 [3];
    logic signed [EW-1:0]    r_e2 [3];
    logic signed [UW-1:0]    r_d1u, r_d1v, r_d2u, r_d2v;
    logic signed [PRW-1:0]   r_prod;
    logic                    r_pv;
    logic [2:0]              r_tag;
    logic signed [AW-1:0]    r_acc;
    logic signed [AW-1:0]    r_res [4];
    logic [NW-1:0]           r_mag [3];
    logic                    r_sgn [3];
    logic                    r_degen;
    logic [61:0]             r_sqp;
    logic                    r_sqv;
    logic [63:0]             r_x, r_r, r_bit;
    logic [31:0]             r_rem;
    logic [QB-1:0]           r_num, r_q;
    logic signed [TAN_W-1:0] r_tan [3];
    t_res                    r_out;
    logic                    r_ovalid;

    logic signed [UW-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    logic [NW-1:0]           or_w;
    logic [30:0]             sq_a, div_m;
    logic [31:0]             len;
    logic [DW-1:0]           num;
    logic [32:0]             tr;
    logic                    ge;
    logic [TAN_W-1:0]        sat;
    logic                    det_zero, tan_zero;

    // Pick multiplier operands for each product step
    always_comb begin
        case (i_cmd.mul_idx)
            3'd0: begin mul_a = r_d1u; mul_b = MB'(r_d2v);  end
            3'd1: begin mul_a = r_d2u; mul_b = MB'(r_d1v);  end
            3'd2: begin mul_a = r_d2v; mul_b = MB'(r_e1[0]); end
            3'd3: begin mul_a = r_d1v; mul_b = MB'(r_e2[0]); end
            3'd4: begin mul_a = r_d2v; mul_b = MB'(r_e1[1]); end
            3'd5: begin mul_a = r_d1v; mul_b = MB'(r_e2[1]); end
            3'd6: begin mul_a = r_d2v; mul_b = MB'(r_e1[2]); end
            default: begin mul_a = r_d1v; mul_b = MB'(r_e2[2]); end
        endcase
    end

    // Status and small combinational helpers
    always_comb begin
        det_zero = (r_res[0] == '0);
        tan_zero = (r_res[1] == '0) && (r_res[2] == '0) && (r_res[3] == '0);
        or_w     = r_mag[0] | r_mag[1] | r_mag[2];
        case (i_cmd.sq_idx)
            2'd0:    sq_a = r_mag[0][30:0];
            2'd1:    sq_a = r_mag[1][30:0];
            default: sq_a = r_mag[2][30:0];
        endcase
        case (i_cmd.comp)
            2'd0:    div_m = r_mag[0][30:0];
            2'd1:    div_m = r_mag[1][30:0];
            default: div_m = r_mag[2][30:0];
        endcase
        len = r_r[31:0];
        num = (DW'(div_m) << (TAN_W - 1)) + DW'(len >> 1);
        tr  = {r_rem, r_num[QB-1]};
        ge  = (tr >= {1'b0, len});
        sat = (r_q > QB'(TAN_MAX)) ? TAN_MAX : r_q[TAN_W-1:0];
        o_sts.degen     = det_zero || tan_zero;
        o_sts.norm_done = (or_w[NW-1:31] == '0) && or_w[30];
        o_sts.out_free  = !r_ovalid || !i_res_stall;
    end

    // Hold the first two vertices, then the third
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vtx && !i_cmd.vtx_slot) begin
            r_p0[0] <= i_vtx.pos_x; r_p0[1] <= i_vtx.pos_y; r_p0[2] <= i_vtx.pos_z;
            r_u0 <= i_vtx.tex_u; r_v0 <= i_vtx.tex_v;
        end
        if (i_cmd.load_vtx && i_cmd.vtx_slot) begin
            r_p1[0] <= i_vtx.pos_x; r_p1[1] <= i_vtx.pos_y; r_p1[2] <= i_vtx.pos_z;
            r_u1 <= i_vtx.tex_u; r_v1 <= i_vtx.tex_v;
        end
        if (i_cmd.load_last) begin
            r_p2[0] <= i_vtx.pos_x; r_p2[1] <= i_vtx.pos_y; r_p2[2] <= i_vtx.pos_z;
            r_u2 <= i_vtx.tex_u; r_v2 <= i_vtx.tex_v;
        end
    end

    // Form edges and texcoord deltas, floor-reduced for wide fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= EW'(((POS_W+1)'(r_p1[i]) - (POS_W+1)'(r_p0[i])) >>> POS_DROP);
                r_e2[i] <= EW'(((POS_W+1)'(r_p2[i]) - (POS_W+1)'(r_p0[i])) >>> POS_DROP);
            end
            r_d1u <= UW'(((TEX_W+1)'(r_u1) - (TEX_W+1)'(r_u0)) >>> UV_DROP);
            r_d1v <= UW'(((TEX_W+1)'(r_v1) - (TEX_W+1)'(r_v0)) >>> UV_DROP);
            r_d2u <= UW'(((TEX_W+1)'(r_u2) - (TEX_W+1)'(r_u0)) >>> UV_DROP);
            r_d2v <= UW'(((TEX_W+1)'(r_v2) - (TEX_W+1)'(r_v0)) >>> UV_DROP);
        end
    end

    // Multiply, then pair products into determinant and tangent sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
        end
        r_prod <= PRW'(mul_a * mul_b);
        r_tag  <= i_cmd.mul_idx;
        if (r_pv) begin
            if (!r_tag[0]) begin
                r_acc <= AW'(r_prod);
            end else begin
                r_res[r_tag[2:1]] <= r_acc - AW'(r_prod);
            end
        end
    end

    // Apply determinant sign, take magnitudes, then normalize one bit a step
    always_ff @(posedge i_clk) begin
        logic signed [AW-1:0] tv;
        logic signed [AW-1:0] ab;
        if (i_cmd.mag) begin
            for (int i = 0; i < 3; i++) begin
                tv = r_res[0][AW-1] ? -r_res[i+1] : r_res[i+1];
                ab = tv[AW-1] ? -tv : tv;
                r_sgn[i] <= tv[AW-1];
                r_mag[i] <= NW'($unsigned(ab));
            end
            r_degen <= det_zero || tan_zero;
        end else if (i_cmd.norm) begin
            for (int i = 0; i < 3; i++) begin
                if (or_w[NW-1:31] != '0) begin
                    r_mag[i] <= r_mag[i] >> 1;
                end else if (!or_w[30]) begin
                    r_mag[i] <= r_mag[i] << 1;
                end
            end
        end
    end

    // Sum of squares, then bit-pair integer square root
    always_ff @(posedge i_clk) begin
        logic [63:0] rb;
        if (!i_rst_n) begin
            r_sqv <= 1'b0;
        end else begin
            r_sqv <= i_cmd.sq_en;
        end
        r_sqp <= 62'(sq_a * sq_a);
        rb = r_r + r_bit;
        if (i_cmd.sq_clr) begin
            r_x   <= '0;
            r_r   <= '0;
            r_bit <= 64'(1) << 62;
        end else if (r_sqv) begin
            r_x <= r_x + 64'(r_sqp);
        end else if (i_cmd.sqrt_step) begin
            if (r_x >= rb) begin
                r_x <= r_x - rb;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // Restoring division of scaled magnitude by length, one quotient bit a step
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= 32'(num >> QB);
            r_num <= num[QB-1:0];
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? 32'(tr - {1'b0, len}) : tr[31:0];
            r_q   <= {r_q[QB-2:0], ge};
            r_num <= r_num << 1;
        end
        if (i_cmd.div_store) begin
            r_tan[i_cmd.comp] <= r_sgn[i_cmd.comp] ? -$signed(sat) : $signed(sat);
        end
    end

    // Output register: load a finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_res_stall) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            if (r_degen) begin
                r_out <= '{tangent_x: TAN_MAX, tangent_y: '0, tangent_z: '0, degenerate: 1'b1};
            end else begin
                r_out <= '{tangent_x: r_tan[0], tangent_y: r_tan[1],
                           tangent_z: r_tan[2], degenerate: 1'b0};
            end
        end
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;

endmodule

/* sv/ttu_ctrl.sv */
// Sequencer: vertex counting and the per-triangle step schedule.
module ttu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vtx_valid,
    output logic          o_vtx_stall,
    input  ttu_pkg::t_sts i_sts,
    output ttu_pkg::t_cmd o_cmd
);
    import ttu_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DIFF   = 11'b00000000010,
        S_MUL    = 11'b00000000100,
        S_MAG    = 11'b00000001000,
        S_NORM   = 11'b00000010000,
        S_SQ     = 11'b00000100000,
        S_SQRT   = 11'b00001000000,
        S_DINIT  = 11'b00010000000,
        S_DIV    = 11'b00100000000,
        S_DSTORE = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_slot, n_slot;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_comp, n_comp;
    logic             accept;

    assign o_vtx_stall = (r_state != S_IDLE);
    assign accept      = i_vtx_valid && (r_state == S_IDLE);

    // Decode state into datapath commands and next state
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_cnt   = r_cnt;
        n_comp  = r_comp;
        o_cmd   = '0;
        o_cmd.vtx_slot = r_slot[0];
        o_cmd.mul_idx  = r_cnt[2:0];
        o_cmd.sq_idx   = r_cnt[1:0];
        o_cmd.comp     = r_comp;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_slot != 2'd2) begin
                        o_cmd.load_vtx = 1'b1;
                        n_slot = r_slot + 2'd1;
                    end else begin
                        o_cmd.load_last = 1'b1;
                        n_slot  = 2'd0;
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = (r_cnt < CNT_W'(MUL_STEPS));
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_STEPS)) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                o_cmd.mag = 1'b1;
                n_state = i_sts.degen ? S_OUT : S_NORM;
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                n_cnt = '0;
                if (i_sts.norm_done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq_clr = (r_cnt == '0);
                o_cmd.sq_en  = (r_cnt < CNT_W'(SQ_STEPS));
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_STEPS)) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_comp  = '0;
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DSTORE;
                end
            end
            S_DSTORE: begin
                o_cmd.div_store = 1'b1;
                n_comp = r_comp + 2'd1;
                n_state = (r_comp == 2'd2) ? S_OUT : S_DINIT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_cnt   <= '0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
        end
    end

`ifndef NO_ASSERTIONS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3) else $error("vertex slot out of range");
    a_mul_to_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_cnt == CNT_W'(MUL_STEPS)) |=> r_state == S_MAG)
        else $error("product phase did not end in magnitude step");
    a_degen_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAG && i_sts.degen) |=> r_state == S_OUT)
        else $error("degenerate triangle entered normalization");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over an untaken word");
`endif

endmodule

/* sv/triangle_tangent_unit.sv */
// Top level of the triangle tangent unit: sequencer plus datapath.
//
//  channel | direction | handshake                   | word
//  vertex  | in        | i_vtx_valid / o_vtx_stall   | i_vtx  (t_vtx)
//  tangent | out       | o_res_valid / i_res_stall   | o_res  (t_res)
//
// The first two vertices of a triangle are only stored. The third starts
// the triangle work, set mostly by the 32-step square root and three divisions
// (init, 17 quotient steps, store) and lengthened by each normalizing shift;
// a degenerate triangle skips straight to the output load.
// The vertex input stalls from the third vertex until the result is loaded.
// Reset is synchronous, active low, and waits for a first vertex.
// The result sits in an output register; a stalled result only holds the
// next triangle's final load, and that triangle's vertices are taken meanwhile.
module triangle_tangent_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vtx_valid,
    output logic          o_vtx_stall,
    input  ttu_pkg::t_vtx i_vtx,
    output logic          o_res_valid,
    input  logic          i_res_stall,
    output ttu_pkg::t_res o_res
);
    import ttu_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ttu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vtx_valid (i_vtx_valid),
        .o_vtx_stall (o_vtx_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ttu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vtx       (i_vtx),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_stall (i_res_stall)
    );

endmodule

/* sim/triangle_tangent_unit_checker.sv */
// Tangent checker: watches both channels, predicts each triangle tangent and compares.
module triangle_tangent_unit_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vtx_valid,
    input  logic          i_vtx_stall,
    input  ttu_pkg::t_vtx i_vtx,
    input  logic          i_res_valid,
    input  logic          i_res_stall,
    input  ttu_pkg::t_res i_res,
    output int            o_fail_count,
    output int            o_pending
);
    import ttu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    t_vtx       held_vtx [2];
    logic [1:0] next_corner;
    t_res       tangent_queue [$];

    assign o_pending = tangent_queue.size();

    // Integer square root, floor.
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= r + bit_v) begin
                x -= r + bit_v;
                r = (r >> 1) + bit_v;
            end else begin
                r >>= 1;
            end
            bit_v >>= 2;
        end
        return r;
    endfunction

    // Form the unit tangent of one triangle.
    function automatic t_res tangent_of(input t_vtx a, input t_vtx b, input t_vtx c);
        t_res            r;
        longint          e1 [3];
        longint          e2 [3];
        longint          t [3];
        longint unsigned m [3];
        longint          d1u, d1v, d2u, d2v, det;
        longint unsigned maxm, len, q;
        int              nb;
        e1[0] = longint'(b.pos_x) - longint'(a.pos_x);
        e1[1] = longint'(b.pos_y) - longint'(a.pos_y);
        e1[2] = longint'(b.pos_z) - longint'(a.pos_z);
        e2[0] = longint'(c.pos_x) - longint'(a.pos_x);
        e2[1] = longint'(c.pos_y) - longint'(a.pos_y);
        e2[2] = longint'(c.pos_z) - longint'(a.pos_z);
        d1u = longint'(b.tex_u) - longint'(a.tex_u);
        d1v = longint'(b.tex_v) - longint'(a.tex_v);
        d2u = longint'(c.tex_u) - longint'(a.tex_u);
        d2v = longint'(c.tex_v) - longint'(a.tex_v);
        r = '0;
        r.tangent_x = TAN_MAX;
        r.degenerate = 1'b1;
        det = d1u * d2v - d2u * d1v;
        if (det == 0) return r;
        maxm = 0;
        for (int i = 0; i < 3; i++) begin
            t[i] = d2v * e1[i] - d1v * e2[i];
            if (det < 0) t[i] = -t[i];
            m[i] = (t[i] < 0) ? longint'(-t[i]) : t[i];
            if (m[i] > maxm) maxm = m[i];
        end
        if (maxm == 0) return r;
        // Scale so the largest magnitude lands in [2^30, 2^31).
        nb = 0;
        while ((maxm >> nb) != 0) nb++;
        for (int i = 0; i < 3; i++)
            m[i] = (nb > 31) ? (m[i] >> (nb - 31)) : (m[i] << (31 - nb));
        len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << (TAN_W - 1)) + len / 2) / len;
            if (q > TAN_MAX) q = TAN_MAX;
            q = (t[i] < 0) ? -q : q;
            case (i)
                0: r.tangent_x = q[TAN_W-1:0];
                1: r.tangent_y = q[TAN_W-1:0];
                default: r.tangent_z = q[TAN_W-1:0];
            endcase
        end
        r.degenerate = 1'b0;
        return r;
    endfunction

    // Track vertices and compare tangents.
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            next_corner <= '0;
            o_fail_count <= 0;
        end else begin
            if (i_vtx_valid && !i_vtx_stall) begin
                if (next_corner < 2'd2) begin
                    held_vtx[next_corner[0]] <= i_vtx;
                    next_corner <= next_corner + 2'd1;
                end else begin
                    tangent_queue = {tangent_queue,
                                     tangent_of(held_vtx[0], held_vtx[1], i_vtx)};
                    next_corner <= '0;
                end
            end
            if (i_res_valid && !i_res_stall) begin
                if (tangent_queue.size() == 0) begin
                    $error("tangent word with none expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = tangent_queue.pop_front();
                    if (want !== i_res) begin
                        o_fail_count <= o_fail_count + 1;
                        if (want.tangent_x !== i_res.tangent_x)
                            $error("tangent_x: expected %0d, got %0d",
                                   want.tangent_x, i_res.tangent_x);
                        if (want.tangent_y !== i_res.tangent_y)
                            $error("tangent_y: expected %0d, got %0d",
                                   want.tangent_y, i_res.tangent_y);
                        if (want.tangent_z !== i_res.tangent_z)
                            $error("tangent_z: expected %0d, got %0d",
                                   want.tangent_z, i_res.tangent_z);
                        if (want.degenerate !== i_res.degenerate)
                            $error("degenerate: expected %0d, got %0d",
                                   want.degenerate, i_res.degenerate);
                    end
                end
            end
        end
    end
endmodule

/* sim/triangle_tangent_unit_tb.sv */
// Testbench top: drives vertices and tangent stalls, and reports the verdict.
module triangle_tangent_unit_tb;
    import ttu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
    localparam int POS_MIN = -(1 << (POS_W - 1));
    localparam int TEX_MAX = (1 << (TEX_W - 1)) - 1;
    localparam int TEX_MIN = -(1 << (TEX_W - 1));
    localparam int RANDOM_TRIANGLES = 510;

    logic i_clk;
    logic i_rst_n;
    logic i_vtx_valid;
    logic o_vtx_stall;
    t_vtx i_vtx;
    logic o_res_valid;
    logic i_res_stall;
    t_res o_res;
    int   fail_count;
    int   pending;
    bit   hold_off;
    bit   feed_done;

    triangle_tangent_unit DUT (.*);

    triangle_tangent_unit_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vtx_valid (i_vtx_valid),
        .i_vtx_stall (o_vtx_stall),
        .i_vtx       (i_vtx),
        .i_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .i_res       (o_res),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Generous limit on the whole run.
    initial begin
        #8ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_vtx vertex_of(input int x, input int y, input int z,
                                       input int u, input int v);
        t_vtx w;
        w.pos_x = x[POS_W-1:0];
        w.pos_y = y[POS_W-1:0];
        w.pos_z = z[POS_W-1:0];
        w.tex_u = u[TEX_W-1:0];
        w.tex_v = v[TEX_W-1:0];
        return w;
    endfunction

    // Offer one word after a random gap, unless no_gap is set, and wait for acceptance.
    task automatic send_vertex(input t_vtx w, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
        if (gap > 0) begin
            i_vtx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_vtx_valid <= 1'b1;
        i_vtx <= w;
        @(posedge i_clk);
        while (o_vtx_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_vtx random_vertex(input int mode);
        case (mode)
            0: return vertex_of(POS_MIN + $urandom_range(0, 3), POS_MAX - $urandom_range(0, 3),
                                $urandom_range(0, 1) ? POS_MIN : POS_MAX,
                                $urandom_range(0, 1) ? TEX_MIN : TEX_MAX,
                                $urandom_range(0, 1) ? TEX_MIN : TEX_MAX);
            1: return vertex_of($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                                $urandom_range(0, 64) - 32, $urandom_range(0, 8) - 4,
                                $urandom_range(0, 8) - 4);
            default: return t_vtx'({$urandom, $urandom, $urandom});
        endcase
    endfunction

    // Directed triangles, then random ones.
    task automatic feed_vertices();
        t_vtx tri_vtx [9][3];
        t_vtx w;
        int   mode;
        // Ordinary right triangle.
        tri_vtx[0] = '{vertex_of(0, 0, 0, 0, 0), vertex_of(65536, 0, 0, 65536, 0),
                       vertex_of(0, 65536, 0, 0, 65536)};
        // Mirrored UVs: negative determinant.
        tri_vtx[1] = '{vertex_of(0, 0, 0, 0, 0), vertex_of(65536, 0, 0, -65536, 0),
                       vertex_of(0, 65536, 0, 0, 65536)};
        // Zero determinant: collinear UVs.
        tri_vtx[2] = '{vertex_of(5, 6, 7, 100, 100), vertex_of(9, 1, 2, 200, 200),
                       vertex_of(3, 3, 3, 300, 300)};
        // Zero tangent: all positions equal.
        tri_vtx[3] = '{vertex_of(77, 77, 77, 0, 0), vertex_of(77, 77, 77, 1000, 0),
                       vertex_of(77, 77, 77, 0, 1000)};
        // Extreme positions and texcoords.
        tri_vtx[4] = '{vertex_of(POS_MIN, POS_MIN, POS_MIN, TEX_MIN, TEX_MIN),
                       vertex_of(POS_MAX, POS_MAX, POS_MAX, TEX_MAX, TEX_MIN),
                       vertex_of(POS_MIN, POS_MAX, POS_MIN, TEX_MIN, TEX_MAX)};
        tri_vtx[5] = '{vertex_of(POS_MAX, POS_MIN, POS_MAX, TEX_MAX, TEX_MAX),
                       vertex_of(POS_MIN, POS_MAX, POS_MIN, TEX_MIN, TEX_MAX),
                       vertex_of(POS_MAX, POS_MAX, POS_MIN, TEX_MAX, TEX_MIN)};
        // Tiny tangent: LSB-sized edges.
        tri_vtx[6] = '{vertex_of(0, 0, 0, 0, 0), vertex_of(1, 0, 0, 1, 0),
                       vertex_of(0, 0, 1, 0, 1)};
        // Axis-aligned tangent, saturating component.
        tri_vtx[7] = '{vertex_of(0, 0, 0, 0, 0), vertex_of(0, 0, -300, 7, 0),
                       vertex_of(0, 1, 0, 0, 3)};
        // All ones and zeros.
        tri_vtx[8] = '{vertex_of(-1, -1, -1, -1, -1), vertex_of(0, 0, 0, 0, 0),
                       vertex_of(-1, 0, -1, 0, -1)};
        foreach (tri_vtx[t])
            for (int k = 0; k < 3; k++) send_vertex(tri_vtx[t][k], 1'b0);
        // Random triangles: mostly random, some small, some extreme, some degenerate.
        for (int t = 0; t < RANDOM_TRIANGLES; t++) begin
            mode = $urandom_range(0, 9);
            for (int k = 0; k < 3; k++) begin
                w = random_vertex(mode < 6 ? 2 : (mode < 8 ? 1 : 0));
                // Occasionally repeat a UV or position to hit degenerate paths.
                if (mode == 9 && k > 0) begin
                    w.tex_u = i_vtx.tex_u;
                    if ($urandom_range(0, 1)) w.tex_v = i_vtx.tex_v;
                    else {w.pos_x, w.pos_y, w.pos_z} = {i_vtx.pos_x, i_vtx.pos_y, i_vtx.pos_z};
                end
                send_vertex(w, t >= 100 && t < 140);
            end
        end
        i_vtx_valid <= 1'b0;
    endtask

    // Receiver stalls: random per word, held during the long hold-off.
    initial begin
        int gap;
        i_res_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_res_stall <= 1'b1;
            end else if (o_res_valid) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                if (gap > 0) begin
                    i_res_stall <= 1'b1;
                    repeat (gap) @(negedge i_clk);
                end
                i_res_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_res_stall <= ($urandom_range(0, 1) == 1);
            end
        end
    end

    initial begin
        int settle;
        i_rst_n = 1'b0;
        i_vtx_valid = 1'b0;
        i_vtx = '0;
        feed_done = 1'b0;
        hold_off = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        fork
            feed_vertices();
            // Long hold-off on results while vertices keep coming.
            begin
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b1;
                repeat (1500) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        feed_done = 1'b1;
        while (pending != 0) @(posedge i_clk);
        settle = 0;
        while (settle < 200) begin
            @(posedge i_clk);
            settle++;
        end
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
